/* hw/rtl/u16u8fnv_pkg.sv */
package u16u8fnv_pkg;

  typedef logic [7:0] byte_t;

  // UTF-8 encoding of one code point: bytes[0] is sent first.
  typedef struct packed {
    byte_t [3:0] bytes;
    logic  [2:0] len;
  } utf8_enc_t;

  localparam logic [63:0] FnvBasis    = 64'hcbf29ce484222325;
  // The 64-bit prime is 2^40 + 0x1b3.
  localparam logic [8:0]  FnvPrimeLo  = 9'h1b3;
  localparam int unsigned FnvPrimeSh  = 40;
  localparam logic [20:0] CpReplace   = 21'h00fffd;
  localparam logic [20:0] CpSuppBase  = 21'h010000;
  localparam logic [5:0]  HighSurTag  = 6'b110110;
  localparam logic [5:0]  LowSurTag   = 6'b110111;

  function automatic utf8_enc_t utf8_encode(input logic [20:0] cp);
    utf8_enc_t enc;
    enc.bytes = '0;
    if (cp <= 21'h00007f) begin
      enc.len      = 3'd1;
      enc.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp <= 21'h0007ff) begin
      enc.len      = 3'd2;
      enc.bytes[0] = {3'b110, cp[10:6]};
      enc.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'h00ffff) begin
      enc.len      = 3'd3;
      enc.bytes[0] = {4'b1110, cp[15:12]};
      enc.bytes[1] = {2'b10, cp[11:6]};
      enc.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      enc.len      = 3'd4;
      enc.bytes[0] = {5'b11110, cp[20:18]};
      enc.bytes[1] = {2'b10, cp[17:12]};
      enc.bytes[2] = {2'b10, cp[11:6]};
      enc.bytes[3] = {2'b10, cp[5:0]};
    end
    return enc;
  endfunction

  // One FNV-1a round: xor the byte in, multiply by the prime modulo 2^64.
  function automatic logic [63:0] fnv_round(input logic [63:0] h, input byte_t b);
    logic [63:0] hx;
    logic [72:0] prod;
    hx   = h ^ {56'd0, b};
    prod = {9'd0, hx} * {64'd0, FnvPrimeLo};
    return (hx << FnvPrimeSh) + prod[63:0];
  endfunction

endpackage

/* hw/rtl/utf16_to_utf8_fnv1a64_hash.sv */
// Channel  Direction  Handshake              Payload
// in       sink       in_valid_i/in_ready_o  code_unit_i, unit_present_i, is_last_i
// out      source     out_valid_o/out_ready_i digest_o
//
// An item is accepted and encoded while idle, then each UTF-8 byte it
// produces (zero to six) is folded in StFold, since the single FNV round unit folds
// one byte per cycle. A last item then passes through StEmit to load the digest.
// The input is ready only when the sequencer is idle. A digest waits in the
// output register; a later last item stalls until that register is free.
// Reset sets the hash to the offset basis and drops any held surrogate.
module utf16_to_utf8_fnv1a64_hash
  import u16u8fnv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        unit_present_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StFold = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [63:0]      hash_q, hash_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             last_q, last_d;
  logic             pend_q, pend_d;
  logic [9:0]       ph_q, ph_d;
  logic             out_valid_q, out_valid_d;
  logic [63:0]      digest_q, digest_d;
  byte_t [7:0]      byte_q, byte_d;

  logic             in_acc;
  logic             is_high, is_low;
  logic             has_a, has_b;
  logic [20:0]      cp_a, cp_b, cp_unit;
  utf8_enc_t        enc_a, enc_b;
  logic [2:0]       len_a, len_b;
  logic [3:0]       len_sum;
  byte_t [7:0]      merged;

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign digest_o    = digest_q;

  assign is_high = (code_unit_i[15:10] == HighSurTag);
  assign is_low  = (code_unit_i[15:10] == LowSurTag);
  assign cp_unit = is_low ? CpReplace : {5'd0, code_unit_i};

  // Up to two code points come out of one item; the surrogate state moves here.
  always_comb begin
    has_a = 1'b0;
    has_b = 1'b0;
    cp_a  = CpReplace;
    cp_b  = CpReplace;
    pend_d = pend_q;
    ph_d   = ph_q;
    if (unit_present_i) begin
      if (pend_q && is_low) begin
        has_a  = 1'b1;
        cp_a   = CpSuppBase + {1'b0, ph_q, code_unit_i[9:0]};
        pend_d = 1'b0;
      end else begin
        if (pend_q) begin
          has_a  = 1'b1;
          pend_d = 1'b0;
        end
        if (is_high) begin
          pend_d = 1'b1;
          ph_d   = code_unit_i[9:0];
        end else if (pend_q) begin
          has_b = 1'b1;
          cp_b  = cp_unit;
        end else begin
          has_a = 1'b1;
          cp_a  = cp_unit;
        end
      end
    end
    if (is_last_i) begin
      if (pend_d) begin
        if (has_a) begin
          has_b = 1'b1;
        end else begin
          has_a = 1'b1;
        end
      end
      pend_d = 1'b0;
      ph_d   = '0;
    end
    if (!in_acc) begin
      pend_d = pend_q;
      ph_d   = ph_q;
    end
  end

  assign enc_a   = utf8_encode(cp_a);
  assign enc_b   = utf8_encode(cp_b);
  assign len_a   = has_a ? enc_a.len : 3'd0;
  assign len_b   = has_b ? enc_b.len : 3'd0;
  assign len_sum = {1'b0, len_a} + {1'b0, len_b};

  always_comb begin
    logic [3:0] pos;
    logic [3:0] rel;
    for (int i = 0; i < 8; i++) begin
      pos = 4'(i);
      rel = pos - {1'b0, len_a};
      if (pos < {1'b0, len_a}) begin
        merged[i] = enc_a.bytes[pos[1:0]];
      end else if (rel < {1'b0, len_b}) begin
        merged[i] = enc_b.bytes[rel[1:0]];
      end else begin
        merged[i] = '0;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    byte_d      = byte_q;
    digest_d    = digest_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          byte_d = merged;
          cnt_d  = len_sum;
          last_d = is_last_i;
          if (len_sum != 4'd0) begin
            state_d = StFold;
          end else if (is_last_i) begin
            state_d = StEmit;
          end
        end
      end
      StFold: begin
        hash_d = fnv_round(hash_q, byte_q[0]);
        byte_d = byte_q >> 8;
        cnt_d  = cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          state_d = last_q ? StEmit : StIdle;
        end
      end
      StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          digest_d    = hash_q;
          out_valid_d = 1'b1;
          hash_d      = FnvBasis;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      hash_q      <= FnvBasis;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      pend_q      <= 1'b0;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      pend_q      <= pend_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    digest_q <= digest_d;
  end

endmodule

/* sim/utf16_to_utf8_fnv1a64_hash_tb.sv */
module utf16_to_utf8_fnv1a64_hash_tb;

  localparam logic [63:0] HashBasis  = 64'hcbf29ce484222325;
  localparam logic [63:0] HashPrime  = 64'h00000100000001b3;
  localparam logic [5:0]  HighPrefix = 6'b110110;
  localparam logic [5:0]  LowPrefix  = 6'b110111;
  localparam logic [20:0] Replacement = 21'h00fffd;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 1300;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [15:0] code_unit_i    = '0;
  logic        unit_present_i = 1'b0;
  logic        is_last_i      = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [63:0] digest_o;

  // Predictor state for the text in flight.
  logic [63:0] hash_acc = HashBasis;
  logic [9:0]  held_high_bits = '0;
  logic        held_high_valid = 1'b0;
  logic [63:0] expected_digests[$];

  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles_left = 0;
  int unsigned stall_left = 0;
  bit          src_idles = 1'b1;
  bit          sink_idles = 1'b1;

  utf16_to_utf8_fnv1a64_hash DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .code_unit_i    (code_unit_i),
    .unit_present_i (unit_present_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digest_o       (digest_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic void fold_octet(input logic [7:0] octet);
    hash_acc = (hash_acc ^ {56'd0, octet}) * HashPrime;
  endfunction

  function automatic void fold_scalar(input logic [20:0] cp);
    if (cp <= 21'h00007f) begin
      fold_octet({1'b0, cp[6:0]});
    end else if (cp <= 21'h0007ff) begin
      fold_octet({3'b110, cp[10:6]});
      fold_octet({2'b10, cp[5:0]});
    end else if (cp <= 21'h00ffff) begin
      fold_octet({4'b1110, cp[15:12]});
      fold_octet({2'b10, cp[11:6]});
      fold_octet({2'b10, cp[5:0]});
    end else begin
      fold_octet({5'b11110, cp[20:18]});
      fold_octet({2'b10, cp[17:12]});
      fold_octet({2'b10, cp[11:6]});
      fold_octet({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void predict_digest(input logic [15:0] unit, input logic present,
                                         input logic last);
    logic is_high;
    logic is_low;
    is_high = (unit[15:10] == HighPrefix);
    is_low  = (unit[15:10] == LowPrefix);
    if (present) begin
      if (held_high_valid && is_low) begin
        held_high_valid = 1'b0;
        fold_scalar(21'h010000 + {1'b0, held_high_bits, unit[9:0]});
      end else begin
        // A held high surrogate without its low half is replaced first.
        if (held_high_valid) begin
          held_high_valid = 1'b0;
          fold_scalar(Replacement);
        end
        if (is_high) begin
          held_high_bits  = unit[9:0];
          held_high_valid = 1'b1;
        end else if (is_low) begin
          fold_scalar(Replacement);
        end else begin
          fold_scalar({5'd0, unit});
        end
      end
    end
    if (last) begin
      if (held_high_valid) begin
        held_high_valid = 1'b0;
        fold_scalar(Replacement);
      end
      expected_digests.insert(expected_digests.size(), hash_acc);
      hash_acc       = HashBasis;
      held_high_bits = '0;
    end
  endfunction

  // Receiver: a long hold-off when requested, otherwise random stall bursts while sink_idles is set.
  always @(negedge clk_i) begin
    if (hold_cycles_left > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles_left--;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (sink_idles && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, 15);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_digests.size() == 0) begin
        report_mismatch($sformatf("digest %h with none expected", digest_o));
      end else begin
        want = expected_digests.pop_front();
        if (digest_o !== want)
          report_mismatch($sformatf("digest %h, expected %h", digest_o, want));
      end
    end
  end

  task automatic send_item(input logic [15:0] unit, input logic present, input logic last);
    @(negedge clk_i);
    if (src_idles && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    code_unit_i    <= unit;
    unit_present_i <= present;
    is_last_i      <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_digest(unit, present, last);
    items_sent++;
  endtask

  task automatic wait_for_digests();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_digests.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_unit(input int unsigned kind);
    logic [15:0] unit;
    case (kind)
      0: unit = 16'($urandom_range(16'h0000, 16'h007f));
      1: unit = 16'($urandom_range(16'h0080, 16'h07ff));
      2: unit = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(16'h0800, 16'hd7ff))
                                            : 16'($urandom_range(16'he000, 16'hffff));
      3: unit = {HighPrefix, 10'($urandom)};
      4: unit = {LowPrefix, 10'($urandom)};
      default: unit = 16'($urandom);
    endcase
    return unit;
  endfunction

  // Mostly well-formed text with random content, mixed with broken pairs and noise.
  task automatic send_random_text(input int unsigned max_len);
    int unsigned n;
    int unsigned kind;
    n = $urandom_range(0, max_len);
    for (int unsigned i = 0; i < n; i++) begin
      kind = $urandom_range(0, 11);
      case (kind)
        0, 1, 2: send_item(pick_unit(kind), 1'b1, 1'b0);
        3, 4, 5: begin
          send_item(pick_unit(3), 1'b1, 1'b0);
          if ($urandom_range(0, 5) == 0) send_item(16'($urandom), 1'b0, 1'b0);
          send_item(pick_unit(4), 1'b1, 1'b0);
        end
        6: send_item(pick_unit(4), 1'b1, 1'b0);
        7: send_item(pick_unit(3), 1'b1, 1'b0);
        8: send_item(16'($urandom), 1'b0, 1'b0);
        default: send_item(16'($urandom), 1'b1, 1'b0);
      endcase
    end
    if ($urandom_range(0, 1) == 1)
      send_item(16'($urandom), 1'b0, 1'b1);
    else
      send_item(pick_unit($urandom_range(0, 11)), 1'b1, 1'b1);
  endtask

  task automatic test_empty_text();
    send_item(16'hffff, 1'b0, 1'b1);
    send_item(16'h0000, 1'b0, 1'b1);
    wait_for_digests();
  endtask

  task automatic test_encoding_boundaries();
    send_item(16'h0000, 1'b1, 1'b0);
    send_item(16'h007f, 1'b1, 1'b0);
    send_item(16'h0080, 1'b1, 1'b0);
    send_item(16'h07ff, 1'b1, 1'b0);
    send_item(16'h0800, 1'b1, 1'b0);
    send_item(16'hffff, 1'b1, 1'b0);
    send_item(16'hd7ff, 1'b1, 1'b1);
    wait_for_digests();
  endtask

  task automatic test_surrogate_handling();
    send_item(16'hd800, 1'b1, 1'b0);
    send_item(16'hdc00, 1'b1, 1'b0);
    send_item(16'hdbff, 1'b1, 1'b0);
    send_item(16'h5555, 1'b0, 1'b0);
    send_item(16'hdfff, 1'b1, 1'b0);
    // A low surrogate with nothing held, then a high one left unpaired.
    send_item(16'hdc00, 1'b1, 1'b0);
    send_item(16'hd800, 1'b1, 1'b0);
    send_item(16'h0041, 1'b1, 1'b0);
    // A high surrogate followed by another high one that pairs normally.
    send_item(16'hdbff, 1'b1, 1'b0);
    send_item(16'hd83d, 1'b1, 1'b0);
    send_item(16'hde00, 1'b1, 1'b0);
    send_item(16'hd801, 1'b1, 1'b0);
    send_item(16'haaaa, 1'b0, 1'b1);
    // The last request itself carries a high surrogate.
    send_item(16'hdbfe, 1'b1, 1'b1);
    wait_for_digests();
  endtask

  task automatic test_back_pressure();
    src_idles = 1'b0;
    @(posedge clk_i);
    hold_cycles_left = 300;
    for (int i = 0; i < 10; i++) send_random_text(3);
    wait_for_digests();
    src_idles = 1'b1;
  endtask

  task automatic test_random_texts();
    while (items_sent < RandomItems) begin
      // Switch idling on and off so that some stretches run at full rate.
      if ($urandom_range(0, 7) == 0) begin
        src_idles  = $urandom_range(0, 2) != 0;
        sink_idles = $urandom_range(0, 2) != 0;
      end
      send_random_text(12);
    end
    wait_for_digests();
  endtask

  task automatic test_full_rate();
    src_idles  = 1'b0;
    sink_idles = 1'b0;
    for (int i = 0; i < 15; i++) send_random_text(10);
    wait_for_digests();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_text();
    test_encoding_boundaries();
    test_surrogate_handling();
    test_back_pressure();
    test_random_texts();
    test_full_rate();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
